[rtl/wsak_pkg.sv]
// Package for the WebSocket accept-key engine: payload types, SHA-1 constants,
// GUID and base64 tables. No dependencies.
package wsak_pkg;

    typedef struct packed {
        logic [7:0] key_byte;
        logic       key_last;
    } key_item_t;

    typedef struct packed {
        logic [7:0] accept_char;
        logic       char_last;
    } char_item_t;

    localparam int GUID_LEN   = 36;
    localparam int ACCEPT_LEN = 28;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [7:0] EQ_CHAR   = 8'h3D;
    localparam logic [5:0] SIX_MASK  = 6'h3F;

    function automatic logic [31:0] round_k(input logic [6:0] r);
        if (r < 7'd20)      return 32'h5A827999;
        else if (r < 7'd40) return 32'h6ED9EBA1;
        else if (r < 7'd60) return 32'h8F1BBCDC;
        else                return 32'hCA62C1D6;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        if (r < 7'd20)      return (b & c) | (~b & d);
        else if (r < 7'd40) return b ^ c ^ d;
        else if (r < 7'd60) return (b & c) | (b & d) | (c & d);
        else                return b ^ c ^ d;
    endfunction

    function automatic logic [7:0] guid_char(input logic [5:0] i);
        logic [7:0] ch;
        unique case (i)
            6'd0: ch = "2";  6'd1: ch = "5";  6'd2: ch = "8";  6'd3: ch = "E";
            6'd4: ch = "A";  6'd5: ch = "F";  6'd6: ch = "A";  6'd7: ch = "5";
            6'd8: ch = "-";  6'd9: ch = "E";  6'd10: ch = "9"; 6'd11: ch = "1";
            6'd12: ch = "4"; 6'd13: ch = "-"; 6'd14: ch = "4"; 6'd15: ch = "7";
            6'd16: ch = "D"; 6'd17: ch = "A"; 6'd18: ch = "-"; 6'd19: ch = "9";
            6'd20: ch = "5"; 6'd21: ch = "C"; 6'd22: ch = "A"; 6'd23: ch = "-";
            6'd24: ch = "C"; 6'd25: ch = "5"; 6'd26: ch = "A"; 6'd27: ch = "B";
            6'd28: ch = "0"; 6'd29: ch = "D"; 6'd30: ch = "C"; 6'd31: ch = "8";
            6'd32: ch = "5"; 6'd33: ch = "B"; 6'd34: ch = "1"; 6'd35: ch = "1";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        if (v < 6'd26)      return 8'h41 + {2'b00, v};
        else if (v < 6'd52) return 8'h61 + {2'b00, v - 6'd26};
        else if (v < 6'd62) return 8'h30 + {2'b00, v - 6'd52};
        else if (v == 6'd62) return 8'h2B;
        else                return 8'h2F;
    endfunction

endpackage

[rtl/wsak_core.sv]
// SHA-1 byte absorber and round engine around a 16-word schedule memory.
// Depends on wsak_pkg.
module wsak_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         byte_valid,
    input  logic [7:0]   byte_data,
    input  logic         byte_counted,
    output logic         byte_ready,
    input  logic         hash_clear,
    output logic [159:0] digest,
    output logic [5:0]   fill,
    output logic [60:0]  count
);
    import wsak_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_RD, S_WR, S_RND_RD, S_RND, S_ADD} state_t;

    logic [31:0] sched_mem [16];
    logic [31:0] rd_data_reg;
    logic [3:0]  rd_addr;
    logic        wr_en;
    logic [3:0]  wr_addr;
    logic [31:0] wr_data;

    state_t      state_reg;
    logic [31:0] h_reg [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [6:0]  rnd_reg;
    logic [5:0]  fill_reg;
    logic [60:0] count_reg;
    logic [7:0]  byte_reg;
    logic        cnt_reg;

    logic [31:0] t_val;
    logic [3:0]  slot;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            sched_mem[wr_addr] <= wr_data;
        rd_data_reg <= sched_mem[rd_addr];
    end

    // rounds 0..15 read w[r]; later rounds read w[r-3],w[r-8],w[r-14],w[r-16]
    // serially is costly, so use a 16-entry ring rewritten in place: one
    // recompute step keeps four reads per round, done here by a small counter.
    logic [1:0]  sub_reg;
    logic [31:0] acc_reg;

    always_comb
    begin
        slot = rnd_reg[3:0];
        unique case (sub_reg)
            2'd0: rd_addr = slot + 4'd13;
            2'd1: rd_addr = slot + 4'd8;
            2'd2: rd_addr = slot + 4'd2;
            default: rd_addr = slot;
        endcase
        if (state_reg == S_IDLE || state_reg == S_RD)
            rd_addr = fill_reg[5:2];
        if (state_reg == S_RND_RD && rnd_reg < 7'd16)
            rd_addr = slot;
    end

    logic [31:0] w_raw;
    assign w_raw = acc_reg ^ rd_data_reg;
    logic [31:0] w_fin;
    assign w_fin = (rnd_reg < 7'd16) ? rd_data_reg : {w_raw[30:0], w_raw[31]};
    assign t_val = {a_reg[26:0], a_reg[31:27]} + round_f(rnd_reg, b_reg, c_reg, d_reg)
                 + e_reg + round_k(rnd_reg) + w_fin;

    logic [4:0] sh;
    assign sh = {~fill_reg[1:0], 3'b000};

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = fill_reg[5:2];
        wr_data = (rd_data_reg & ~(32'hFF << sh)) | ({24'd0, byte_reg} << sh);
        if (state_reg == S_WR)
            wr_en = 1'b1;
        if (state_reg == S_RND && rnd_reg >= 7'd16 && sub_reg == 2'd0)
        begin
            wr_en   = 1'b1;
            wr_addr = slot;
            wr_data = w_fin;
        end
    end

    assign byte_ready = (state_reg == S_IDLE);
    assign digest = {h_reg[0], h_reg[1], h_reg[2], h_reg[3], h_reg[4]};
    assign fill  = fill_reg;
    assign count = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            h_reg[0] <= H0_INIT; h_reg[1] <= H1_INIT; h_reg[2] <= H2_INIT;
            h_reg[3] <= H3_INIT; h_reg[4] <= H4_INIT;
            fill_reg <= '0;
            count_reg <= '0;
            rnd_reg <= '0;
            sub_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (hash_clear)
                    begin
                        h_reg[0] <= H0_INIT; h_reg[1] <= H1_INIT; h_reg[2] <= H2_INIT;
                        h_reg[3] <= H3_INIT; h_reg[4] <= H4_INIT;
                        fill_reg <= '0;
                        count_reg <= '0;
                    end
                    else if (byte_valid)
                    begin
                        byte_reg <= byte_data;
                        cnt_reg  <= byte_counted;
                        state_reg <= S_RD;
                    end
                end
                S_RD: state_reg <= S_WR;
                S_WR:
                begin
                    fill_reg <= fill_reg + 6'd1;
                    if (cnt_reg)
                        count_reg <= count_reg + 61'd1;
                    if (fill_reg == 6'd63)
                    begin
                        a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2];
                        d_reg <= h_reg[3]; e_reg <= h_reg[4];
                        rnd_reg <= '0;
                        sub_reg <= '0;
                        state_reg <= S_RND_RD;
                    end
                    else
                        state_reg <= S_IDLE;
                end
                S_RND_RD:
                begin
                    // read issued; for rounds >=16 gather four words
                    if (rnd_reg < 7'd16)
                    begin
                        sub_reg <= 2'd0;
                        state_reg <= S_RND;
                    end
                    else
                    begin
                        sub_reg <= 2'd1;
                        acc_reg <= '0;
                        state_reg <= S_RND;
                    end
                end
                S_RND:
                begin
                    if (rnd_reg >= 7'd16 && sub_reg != 2'd0)
                    begin
                        acc_reg <= acc_reg ^ rd_data_reg;
                        sub_reg <= sub_reg + 2'd1;
                    end
                    else
                    begin
                        e_reg <= d_reg;
                        d_reg <= c_reg;
                        c_reg <= {b_reg[1:0], b_reg[31:2]};
                        b_reg <= a_reg;
                        a_reg <= t_val;
                        sub_reg <= '0;
                        rnd_reg <= rnd_reg + 7'd1;
                        state_reg <= (rnd_reg == 7'd79) ? S_ADD : S_RND_RD;
                    end
                end
                S_ADD:
                begin
                    h_reg[0] <= h_reg[0] + a_reg; h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg; h_reg[3] <= h_reg[3] + d_reg;
                    h_reg[4] <= h_reg[4] + e_reg;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

[rtl/websocket_accept_key_top.sv]
// Top level of the WebSocket accept-key engine: key-byte sequencer, GUID and
// padding feed, base64 output. Depends on wsak_pkg and wsak_core.
//
// Usage: stream the client key on the in channel, one byte per item, with
// key_last set on the final byte. Each byte is written into a 16-word
// schedule memory (read-modify-write). A full 64-byte block runs 80 SHA-1
// rounds; rounds 0-15 read one schedule word and rounds 16-79 read four
// through the single memory port, then the working values are added into
// the hash state.
// On key_last the block feeds the 36-byte GUID, 0x80, zero fill and the
// 64-bit bit length, then sends 28 base64 characters on the out channel,
// the last one '=' with char_last set. in_ready stays low from key_last
// until the clear after the last character is taken; a stalled receiver
// simply holds the character register. After the last character the hash
// state returns to its initial values and the next byte starts a new key.
// Reset (rst_n low, asynchronous) restores the SHA-1 initial values and
// clears the byte counts; the schedule memory needs no clearing.
module websocket_accept_key_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  wsak_pkg::key_item_t   in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output wsak_pkg::char_item_t  out_data
);
    import wsak_pkg::*;

    typedef enum logic [2:0] {T_KEY, T_GUID, T_PAD, T_LEN, T_OUT, T_CLR} tstate_t;

    tstate_t     state_reg;
    logic [5:0]  idx_reg;
    logic [63:0] bits_reg;
    logic [4:0]  ch_reg;
    logic        out_valid_reg;
    char_item_t  out_reg;

    logic         bv, bcnt, brdy, clr;
    logic [7:0]   bdata;
    logic [159:0] dig;
    logic [5:0]   fill;
    logic [60:0]  count;

    wsak_core u_core (
        .clk(clk), .rst_n(rst_n), .byte_valid(bv), .byte_data(bdata),
        .byte_counted(bcnt), .byte_ready(brdy), .hash_clear(clr),
        .digest(dig), .fill(fill), .count(count)
    );

    assign in_ready  = (state_reg == T_KEY) && brdy;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // pick the next 6-bit digit of the digest; digit 27 is the pad
    logic [167:0] dig_ext;
    logic [5:0]   digit;
    logic [7:0]   dpos;
    assign dig_ext = {dig, 8'h00};
    assign dpos  = 8'd162 - 8'd6 * {3'd0, ch_reg};
    assign digit = dig_ext[dpos +: 6] & SIX_MASK;

    always_comb
    begin
        bv = 1'b0; bcnt = 1'b0; bdata = in_data.key_byte; clr = 1'b0;
        unique case (state_reg)
            T_KEY:  begin bv = in_valid; bcnt = 1'b1; end
            T_GUID: begin bv = 1'b1; bcnt = 1'b1; bdata = guid_char(idx_reg); end
            T_PAD:  begin bv = 1'b1; bdata = (idx_reg == 6'd0) ? PAD_BYTE : 8'h00; end
            T_LEN:  begin bv = 1'b1; bdata = bits_reg[63:56]; end
            T_CLR:  clr = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_KEY;
            idx_reg <= '0;
            ch_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                T_KEY:
                    if (in_valid && brdy && in_data.key_last)
                    begin
                        idx_reg <= '0;
                        state_reg <= T_GUID;
                    end
                T_GUID:
                    if (brdy)
                    begin
                        idx_reg <= idx_reg + 6'd1;
                        if (idx_reg == 6'(GUID_LEN - 1))
                        begin
                            idx_reg <= '0;
                            state_reg <= T_PAD;
                        end
                    end
                T_PAD:
                    if (brdy)
                    begin
                        if (idx_reg == 6'd0)
                            bits_reg <= {count, 3'b000};
                        idx_reg <= 6'd1;
                        if (fill == 6'd55)
                        begin
                            idx_reg <= '0;
                            state_reg <= T_LEN;
                        end
                    end
                T_LEN:
                    if (brdy)
                    begin
                        bits_reg <= {bits_reg[55:0], 8'h00};
                        idx_reg <= idx_reg + 6'd1;
                        if (idx_reg == 6'd7)
                        begin
                            ch_reg <= '0;
                            state_reg <= T_OUT;
                        end
                    end
                T_OUT:
                    if (brdy && (!out_valid_reg || out_ready))
                    begin
                        if (out_valid_reg && out_reg.char_last)
                        begin
                            out_valid_reg <= 1'b0;
                            state_reg <= T_CLR;
                        end
                        else
                        begin
                            out_valid_reg <= 1'b1;
                            out_reg.accept_char <= (ch_reg == 5'(ACCEPT_LEN - 1))
                                                   ? EQ_CHAR : b64_char(digit);
                            out_reg.char_last <= (ch_reg == 5'(ACCEPT_LEN - 1));
                            ch_reg <= ch_reg + 5'd1;
                        end
                    end
                T_CLR: state_reg <= T_KEY;
                default: state_reg <= T_KEY;
            endcase
        end
    end
endmodule
